// File: src/bsc_pkg.sv
// Package: shared types, widths, limits and register codes for the baro compensation block
`default_nettype none
package bsc_pkg;

	localparam int RAW_W      = 24;
	localparam int COEFF_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TEMP_W     = 15;
	localparam int PRES_W     = 17;

	localparam int FRONT_STAGES = 6;
	localparam int BACK_STAGES  = 4;
	localparam int PIPE_DEPTH   = FRONT_STAGES + BACK_STAGES;

	localparam logic [CFG_IDX_W-1:0] REG_SENS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TCS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TCO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TREF  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TSENS = 3'd5;

	localparam logic [COEFF_W-1:0] SENS_RST  = 16'd40127;
	localparam logic [COEFF_W-1:0] OFF_RST   = 16'd36924;
	localparam logic [COEFF_W-1:0] TCS_RST   = 16'd23317;
	localparam logic [COEFF_W-1:0] TCO_RST   = 16'd23282;
	localparam logic [COEFF_W-1:0] TREF_RST  = 16'd33464;
	localparam logic [COEFF_W-1:0] TSENS_RST = 16'd28312;

	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;
	localparam logic [PRES_W-1:0]        PRES_MIN = 17'd1000;
	localparam logic [PRES_W-1:0]        PRES_MAX = 17'd120000;

	localparam logic signed [18:0] TEMP_REF   = 19'sd2000;
	localparam logic signed [18:0] FRZ_OFFSET = 19'sd3500;

	typedef struct packed {
		logic [COEFF_W-1:0] sens;
		logic [COEFF_W-1:0] off;
		logic [COEFF_W-1:0] tcs;
		logic [COEFF_W-1:0] tco;
		logic [COEFF_W-1:0] tref;
		logic [COEFF_W-1:0] tsens;
	} coeff_t;

	typedef struct packed {
		logic [RAW_W-1:0]          d1;
		logic signed [40:0]        off;
		logic signed [40:0]        sens;
		logic signed [TEMP_W-1:0]  temp;
		logic                      tclamp;
	} front_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic [PRES_W-1:0]        pressure;
		logic                     clamped;
	} res_t;

endpackage
`default_nettype wire

// File: src/bsc_in_if.sv
// Interface: raw sample channel (pressure and temperature conversions)
`default_nettype none
interface bsc_in_if;
	logic                       valid;
	logic                       ready;
	logic [bsc_pkg::RAW_W-1:0]  raw_pressure;
	logic [bsc_pkg::RAW_W-1:0]  raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface
`default_nettype wire

// File: src/bsc_out_if.sv
// Interface: compensated result channel
`default_nettype none
interface bsc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [bsc_pkg::TEMP_W-1:0]  temperature;
	logic [bsc_pkg::PRES_W-1:0]         pressure;
	logic                               clamped;

	modport source (output valid, output temperature, output pressure, output clamped,
		input ready);
	modport sink (input valid, input temperature, input pressure, input clamped,
		output ready);
endinterface
`default_nettype wire

// File: src/bsc_cfg_regs.sv
// Calibration word registers with write port
`default_nettype none
module bsc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bsc_pkg::COEFF_W-1:0]     cfg_wdata,
	output bsc_pkg::coeff_t                      coeff
);
	bsc_pkg::coeff_t coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q.sens  <= bsc_pkg::SENS_RST;
			coeff_q.off   <= bsc_pkg::OFF_RST;
			coeff_q.tcs   <= bsc_pkg::TCS_RST;
			coeff_q.tco   <= bsc_pkg::TCO_RST;
			coeff_q.tref  <= bsc_pkg::TREF_RST;
			coeff_q.tsens <= bsc_pkg::TSENS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bsc_pkg::REG_SENS:  coeff_q.sens  <= cfg_wdata;
				bsc_pkg::REG_OFF:   coeff_q.off   <= cfg_wdata;
				bsc_pkg::REG_TCS:   coeff_q.tcs   <= cfg_wdata;
				bsc_pkg::REG_TCO:   coeff_q.tco   <= cfg_wdata;
				bsc_pkg::REG_TREF:  coeff_q.tref  <= cfg_wdata;
				bsc_pkg::REG_TSENS: coeff_q.tsens <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign coeff = coeff_q;
endmodule
`default_nettype wire

// File: src/bsc_pipe_ctl.sv
// Pipeline valid chain and per-stage advance enables
`default_nettype none
module bsc_pipe_ctl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [bsc_pkg::PIPE_DEPTH-1:0]      en
);
	localparam int N = bsc_pkg::PIPE_DEPTH;

	logic [N-1:0] vld_q;
	logic [N-1:0] vld_src;

	// a stage advances when empty or when the next one advances
	always_comb begin
		en[N-1] = !vld_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_src = {vld_q[N-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < N; k++) begin
				if (en[k]) vld_q[k] <= vld_src[k];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[N-1];
endmodule
`default_nettype wire

// File: src/bsc_front.sv
// Stages 1-6: first-order terms, second-order corrections, temperature result
`default_nettype none
module bsc_front (
	input  wire logic                               clk,
	input  wire logic [bsc_pkg::FRONT_STAGES-1:0]   en,
	input  wire bsc_pkg::coeff_t                    coeff,
	input  wire logic [bsc_pkg::RAW_W-1:0]          raw_pressure,
	input  wire logic [bsc_pkg::RAW_W-1:0]          raw_temperature,
	output bsc_pkg::front_t                         front
);
	// stage 1
	logic [23:0]          d1_s1;
	logic signed [24:0]   dt_s1;
	// stage 2
	logic [23:0]          d1_s2;
	logic signed [41:0]   pt_s2, pco_s2, pcs_s2;
	logic signed [49:0]   pdd_s2;
	// stage 3
	logic [23:0]          d1_s3;
	logic signed [18:0]   a_s3, b_s3, temp1_s3;
	logic                 cold_s3, frz_s3;
	logic [17:0]          t2_s3;
	logic signed [39:0]   off1_s3, sens1_s3;
	// stage 4
	logic [23:0]          d1_s4;
	logic [33:0]          sq_s4, sq2_s4;
	logic signed [19:0]   temp2_s4;
	logic signed [39:0]   off1_s4, sens1_s4;
	// stage 5
	logic [23:0]          d1_s5;
	logic [38:0]          off2_s5, sens2_s5;
	logic signed [39:0]   off1_s5, sens1_s5;
	logic signed [14:0]   temp_s5;
	logic                 tclamp_s5;
	// stage 6
	bsc_pkg::front_t      front_s6;

	logic signed [18:0]   a_c, b_c;
	logic signed [37:0]   sqa_c, sqb_c;
	logic [38:0]          sq5_c, sq7_c, sq11_c;

	assign a_c   = $signed(pt_s2[41:23]);
	assign b_c   = a_c + bsc_pkg::FRZ_OFFSET;
	assign sqa_c = a_s3 * a_s3;
	assign sqb_c = b_s3 * b_s3;
	assign sq5_c  = {3'b0, sq_s4, 2'b0} + {5'b0, sq_s4};
	assign sq7_c  = {2'b0, sq2_s4, 3'b0} - {5'b0, sq2_s4};
	assign sq11_c = {2'b0, sq2_s4, 3'b0} + {4'b0, sq2_s4, 1'b0} + {5'b0, sq2_s4};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.tref, 8'b0});
		end
		if (en[1]) begin
			d1_s2  <= d1_s1;
			pt_s2  <= dt_s1 * $signed({1'b0, coeff.tsens});
			pco_s2 <= dt_s1 * $signed({1'b0, coeff.tco});
			pcs_s2 <= dt_s1 * $signed({1'b0, coeff.tcs});
			pdd_s2 <= dt_s1 * dt_s1;
		end
		if (en[2]) begin
			d1_s3    <= d1_s2;
			a_s3     <= a_c;
			b_s3     <= b_c;
			temp1_s3 <= a_c + bsc_pkg::TEMP_REF;
			cold_s3  <= a_c[18];
			frz_s3   <= b_c[18];
			t2_s3    <= a_c[18] ? pdd_s2[48:31] : 18'd0;
			off1_s3  <= $signed({8'b0, coeff.off, 16'b0}) + $signed(pco_s2[41:7]);
			sens1_s3 <= $signed({9'b0, coeff.sens, 15'b0}) + $signed(pcs_s2[41:8]);
		end
		if (en[3]) begin
			d1_s4    <= d1_s3;
			sq_s4    <= cold_s3 ? sqa_c[33:0] : 34'd0;
			sq2_s4   <= frz_s3 ? sqb_c[33:0] : 34'd0;
			temp2_s4 <= temp1_s3 - $signed({1'b0, t2_s3});
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
		end
		if (en[4]) begin
			d1_s5    <= d1_s4;
			off2_s5  <= {1'b0, sq5_c[38:1]} + sq7_c;
			sens2_s5 <= {2'b0, sq5_c[38:2]} + {1'b0, sq11_c[38:1]};
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			if (temp2_s4 < bsc_pkg::TEMP_MIN) begin
				temp_s5   <= bsc_pkg::TEMP_MIN;
				tclamp_s5 <= 1'b1;
			end else if (temp2_s4 > bsc_pkg::TEMP_MAX) begin
				temp_s5   <= bsc_pkg::TEMP_MAX;
				tclamp_s5 <= 1'b1;
			end else begin
				temp_s5   <= temp2_s4[14:0];
				tclamp_s5 <= 1'b0;
			end
		end
		if (en[5]) begin
			front_s6.d1     <= d1_s5;
			front_s6.off    <= off1_s5 - $signed({1'b0, off2_s5});
			front_s6.sens   <= sens1_s5 - $signed({1'b0, sens2_s5});
			front_s6.temp   <= temp_s5;
			front_s6.tclamp <= tclamp_s5;
		end
	end

	assign front = front_s6;
endmodule
`default_nettype wire

// File: src/bsc_back.sv
// Stages 7-10: split pressure product, offset removal, final shift and saturation
`default_nettype none
module bsc_back (
	input  wire logic                              clk,
	input  wire logic [bsc_pkg::BACK_STAGES-1:0]   en,
	input  wire bsc_pkg::front_t                   front,
	output bsc_pkg::res_t                          res
);
	// stage 7
	logic [43:0]          plo_s7;
	logic signed [45:0]   phi_s7;
	logic signed [40:0]   off_s7;
	logic signed [14:0]   temp_s7;
	logic                 tclamp_s7;
	// stage 8
	logic signed [65:0]   prod_s8;
	logic signed [40:0]   off_s8;
	logic signed [14:0]   temp_s8;
	logic                 tclamp_s8;
	// stage 9
	logic signed [45:0]   diff_s9;
	logic signed [14:0]   temp_s9;
	logic                 tclamp_s9;
	// stage 10
	bsc_pkg::res_t        res_s10;

	logic signed [30:0]   p_c;
	logic signed [30:0]   pmin_c, pmax_c;

	assign p_c    = $signed(diff_s9[45:15]);
	assign pmin_c = $signed({14'b0, bsc_pkg::PRES_MIN});
	assign pmax_c = $signed({14'b0, bsc_pkg::PRES_MAX});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			plo_s7    <= front.d1 * front.sens[19:0];
			phi_s7    <= $signed({1'b0, front.d1}) * $signed(front.sens[40:20]);
			off_s7    <= front.off;
			temp_s7   <= front.temp;
			tclamp_s7 <= front.tclamp;
		end
		if (en[1]) begin
			prod_s8   <= $signed({phi_s7, 20'b0}) + $signed({22'b0, plo_s7});
			off_s8    <= off_s7;
			temp_s8   <= temp_s7;
			tclamp_s8 <= tclamp_s7;
		end
		if (en[2]) begin
			diff_s9   <= $signed(prod_s8[65:21]) - off_s8;
			temp_s9   <= temp_s8;
			tclamp_s9 <= tclamp_s8;
		end
		if (en[3]) begin
			res_s10.temperature <= temp_s9;
			if (p_c < pmin_c) begin
				res_s10.pressure <= bsc_pkg::PRES_MIN;
				res_s10.clamped  <= 1'b1;
			end else if (p_c > pmax_c) begin
				res_s10.pressure <= bsc_pkg::PRES_MAX;
				res_s10.clamped  <= 1'b1;
			end else begin
				res_s10.pressure <= p_c[16:0];
				res_s10.clamped  <= tclamp_s9;
			end
		end
	end

	assign res = res_s10;
endmodule
`default_nettype wire

// File: src/baro_sensor_compensation.sv
// Top level: second-order barometric pressure and temperature compensation
// Throughput: one sample word per cycle; ten register stages, multipliers split over two.
// A stalled result holds the final stage; earlier empty stages still take new words.
// Reset clears every stage valid bit and loads the factory calibration words.
`default_nettype none
module baro_sensor_compensation (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bsc_pkg::COEFF_W-1:0]     cfg_wdata,
	bsc_in_if.sink                               sample,
	bsc_out_if.source                            result
);
	bsc_pkg::coeff_t                        coeff;
	bsc_pkg::front_t                        front;
	bsc_pkg::res_t                          res;
	logic [bsc_pkg::PIPE_DEPTH-1:0]         en;

	bsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coeff     (coeff)
	);

	bsc_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.en        (en)
	);

	bsc_front u_front (
		.clk             (clk),
		.en              (en[bsc_pkg::FRONT_STAGES-1:0]),
		.coeff           (coeff),
		.raw_pressure    (sample.raw_pressure),
		.raw_temperature (sample.raw_temperature),
		.front           (front)
	);

	bsc_back u_back (
		.clk   (clk),
		.en    (en[bsc_pkg::PIPE_DEPTH-1:bsc_pkg::FRONT_STAGES]),
		.front (front),
		.res   (res)
	);

	assign result.temperature = res.temperature;
	assign result.pressure    = res.pressure;
	assign result.clamped     = res.clamped;
endmodule
`default_nettype wire

// File: src/bsc_check.sv
// Port checker for the compensation block, bound to the top level
`default_nettype none
module bsc_check (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [bsc_pkg::TEMP_W-1:0] temperature,
	input wire logic [bsc_pkg::PRES_W-1:0]        pressure,
	input wire logic                              clamped
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temperature)
			&& $stable(pressure) && $stable(clamped))
		else $error("result word changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature >= bsc_pkg::TEMP_MIN && temperature <= bsc_pkg::TEMP_MAX
			&& pressure >= bsc_pkg::PRES_MIN && pressure <= bsc_pkg::PRES_MAX)
		else $error("result outside sensor range");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> temperature == bsc_pkg::TEMP_MIN
			|| temperature == bsc_pkg::TEMP_MAX || pressure == bsc_pkg::PRES_MIN
			|| pressure == bsc_pkg::PRES_MAX)
		else $error("clamp flag without a limit value");

	a_backpr: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with free output");
endmodule

bind baro_sensor_compensation bsc_check u_bsc_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.temperature (result.temperature),
	.pressure    (result.pressure),
	.clamped     (result.clamped)
);
`default_nettype wire
